>>> rtl/assert_macros.svh
// assertion helpers for the rtl files, included by nearest_palette_color_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge once reset is released
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/npc_pkg.sv
`default_nettype none
package npc_pkg;

    localparam int COLOR_W = 8;
    localparam int SQ_W    = 2 * COLOR_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 4;
    localparam int OUT_IDX_W = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] sq_dist;
        t_rgb              color;
    } t_cand;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

>>> rtl/npc_lane.sv
`default_nettype none
module npc_lane import npc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_rgb  i_pix,
    input  wire t_rgb  i_ent,
    output t_cand      o_cand
);

    logic [COLOR_W-1:0] w_dr, w_dg, w_db;
    logic [SQ_W-1:0]    r_sq_r, r_sq_g, r_sq_b;
    t_rgb               r_color;
    logic               r_vld;
    t_cand              r_cand;

    assign w_dr = abs_diff(i_pix.red,   i_ent.red);
    assign w_dg = abs_diff(i_pix.green, i_ent.green);
    assign w_db = abs_diff(i_pix.blue,  i_ent.blue);

    // stage one: per-channel squares, stage two: their sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vld   <= i_vld;
            r_color <= i_ent;
            r_sq_r  <= SQ_W'(w_dr) * SQ_W'(w_dr);
            r_sq_g  <= SQ_W'(w_dg) * SQ_W'(w_dg);
            r_sq_b  <= SQ_W'(w_db) * SQ_W'(w_db);
            r_cand.vld     <= r_vld;
            r_cand.color   <= r_color;
            r_cand.sq_dist <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
        end
    end

    assign o_cand = r_cand;

endmodule
`default_nettype wire

>>> rtl/npc_min_tree.sv
`default_nettype none
module npc_min_tree import npc_pkg::*; #(
    parameter int LVLS = 3
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire t_cand           i_leaf [2**LVLS],
    output t_cand                o_root,
    output logic [LVLS-1:0]      o_root_idx
);

    localparam int LANES = 2**LVLS;

    // heap numbering: node k has children 2k and 2k+1, leaves sit at LANES and up
    t_cand           r_node [1:LANES-1];
    logic [LVLS-1:0] r_idx  [1:LANES-1];

    for (genvar k = 1; k < LANES; k++) begin : g_node
        t_cand           w_a, w_b;
        logic [LVLS-1:0] w_ai, w_bi;
        logic            w_take_b;

        if (2 * k >= LANES) begin : g_bottom
            assign w_a  = i_leaf[2*k-LANES];
            assign w_b  = i_leaf[2*k+1-LANES];
            assign w_ai = LVLS'(2*k-LANES);
            assign w_bi = LVLS'(2*k+1-LANES);
        end else begin : g_inner
            assign w_a  = r_node[2*k];
            assign w_b  = r_node[2*k+1];
            assign w_ai = r_idx[2*k];
            assign w_bi = r_idx[2*k+1];
        end

        // left side holds the lower indices, so it keeps ties
        assign w_take_b = w_b.vld && (!w_a.vld || (w_b.sq_dist < w_a.sq_dist));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_node[k] <= w_take_b ? w_b  : w_a;
                r_idx[k]  <= w_take_b ? w_bi : w_ai;
            end
        end
    end

    assign o_root     = r_node[1];
    assign o_root_idx = r_idx[1];

endmodule
`default_nettype wire

>>> rtl/nearest_palette_color_top.sv
`default_nettype none
// Nearest palette color. Each pixel beat (tuser high) is matched against
// palette entries 0 .. palette_count-1 by squared RGB distance; the result
// beat carries the winning color and index, lowest index on ties. A load
// beat (tuser low) writes entry entry_index and yields no result; slots at
// or above PALETTE_SIZE are ignored. A count of zero searches entry 0 only,
// a count above PALETTE_SIZE searches them all. The pipeline takes one beat
// per cycle; a pixel passes through two distance-lane stages, one register
// per level of the compare tree (at least one level) and an output register.
// The whole pipeline holds while the output is stalled. Entries must be
// loaded before a pixel searches them. The user must write palette_count over
// the cfg channel only while no pixel is in flight; the block itself does
// not enforce it.
module nearest_palette_color_top import npc_pkg::*; #(
    parameter int PALETTE_SIZE = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CNT_W-1:0]       i_cfg_data,      // palette_count
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // entry_index[2:0], red_in[10:3], green_in[18:11], blue_in[26:19]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                   i_s_axis_tuser,  // kind
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], chosen_index[26:24]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int LVLS  = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int LANES = 2**LVLS;
    localparam int DEPTH = 2 + LVLS;

    logic              w_en, w_accept, w_pixel;
    logic [SLOT_W-1:0] w_slot;
    t_rgb              w_pix;
    logic [CNT_W-1:0]  r_cnt;
    t_rgb              r_pal [PALETTE_SIZE];
    logic [DEPTH-1:0]  r_vld;
    t_cand             w_leaf [LANES];
    t_cand             w_root;
    logic [LVLS-1:0]   w_root_idx;
    logic              r_out_valid;
    t_rgb              r_out_color;
    logic [LVLS-1:0]   r_out_idx;

    assign w_en     = !r_out_valid || i_m_axis_tready;
    assign w_accept = i_s_axis_tvalid && w_en;
    assign w_pixel  = w_accept && (i_s_axis_tuser == KIND_PIXEL);
    assign w_slot   = i_s_axis_tdata[SLOT_W-1:0];
    assign w_pix    = i_s_axis_tdata[SLOT_W +: 3*COLOR_W];

    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            r_cnt <= i_cfg_data;
        end
    end

    // entries beyond the reach of the slot field are never written
    for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_pal
        if (i < 2**SLOT_W) begin : g_wr
            always_ff @(posedge i_clk) begin
                if (w_accept && (i_s_axis_tuser == KIND_LOAD) && (w_slot == SLOT_W'(i))) begin
                    r_pal[i] <= w_pix;
                end
            end
        end else begin : g_nowr
            always_ff @(posedge i_clk) begin
                r_pal[i] <= r_pal[i];
            end
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        if (i < PALETTE_SIZE) begin : g_used
            logic w_lane_on;
            if (i == 0) begin : g_first
                assign w_lane_on = 1'b1;
            end else if (i < 2**CNT_W) begin : g_cmp
                assign w_lane_on = (r_cnt > CNT_W'(i));
            end else begin : g_off
                assign w_lane_on = 1'b0;
            end
            npc_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_vld  (w_lane_on),
                .i_pix  (w_pix),
                .i_ent  (r_pal[i]),
                .o_cand (w_leaf[i])
            );
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    npc_min_tree #(
        .LVLS (LVLS)
    ) u_tree (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_leaf     (w_leaf),
        .o_root     (w_root),
        .o_root_idx (w_root_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[DEPTH-2:0], w_pixel};
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_color <= w_root.color;
            r_out_idx   <= w_root_idx;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({OUT_IDX_W'(r_out_idx), r_out_color});

`include "assert_macros.svh"

    // entry 0 is always searched, so a pixel at the tree root has a winner
    `ASSERT_CLK(a_root_has_winner, r_vld[DEPTH-1] |-> w_root.vld, "no candidate at tree root")
    `ASSERT_CLK(a_idx_in_range, r_out_valid |-> (r_out_idx < LVLS'(PALETTE_SIZE - 1) ||
        r_out_idx == LVLS'(PALETTE_SIZE - 1)), "chosen index beyond palette")
    `ASSERT_CLK(a_load_no_result, (w_accept && i_s_axis_tuser == KIND_LOAD) |=> !r_vld[0],
        "load beat entered the result pipeline")
    `ASSERT_CLK(a_hold_on_stall, !w_en |=> ($stable(r_vld) && r_out_valid),
        "pipeline moved during output stall")

endmodule
`default_nettype wire
